FILE: hdl/sorted_table_binary_search_macros.svh
// ----------------------------------------------------------------------------
// Sorted table binary search assertion macros
// Shared assertion wrappers clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

`ifndef SYNTHESIS

`define STBS_ASSERT_IMPLIES(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("assertion failed in sorted table binary search");

`define STBS_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("assertion failed in sorted table binary search");

`else

`define STBS_ASSERT_IMPLIES(label, cond, prop)

`define STBS_ASSERT_NEXT(label, cond, prop)

`endif

`endif

FILE: hdl/stbs_pkg.sv
// ----------------------------------------------------------------------------
// Sorted table binary search package
// Field widths, command codes and the sequencer state type.
// ----------------------------------------------------------------------------
package stbs_pkg;

   localparam int INDEX_W = 10;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 11;

   typedef logic [INDEX_W-1:0]        index_type;
   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [COUNT_W-1:0]        count_type;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_PROBE  = 4'b0010,
      ST_CMP    = 4'b0100,
      ST_RESULT = 4'b1000
   } state_type;

endpackage

FILE: hdl/stbs_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Carries write and search requests into the search block.
// ----------------------------------------------------------------------------
interface stbs_req_if;

   logic                valid;
   logic                ready;
   logic                command;
   stbs_pkg::index_type entry_index;
   stbs_pkg::value_type value;

   modport source (output valid, output command, output entry_index, output value,
                   input ready);
   modport sink (input valid, input command, input entry_index, input value,
                 output ready);

endinterface

FILE: hdl/stbs_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Carries the found flag and matching position of each search.
// ----------------------------------------------------------------------------
interface stbs_rsp_if;

   logic                valid;
   logic                ready;
   logic                found;
   stbs_pkg::index_type position;

   modport source (output valid, output found, output position, input ready);
   modport sink (input valid, input found, input position, output ready);

endinterface

FILE: hdl/stbs_csr_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Carries writes of the element count register.
// ----------------------------------------------------------------------------
interface stbs_csr_if;

   logic                valid;
   logic                ready;
   stbs_pkg::count_type element_count;

   modport source (output valid, output element_count, input ready);
   modport sink (input valid, input element_count, output ready);

endinterface

FILE: hdl/stbs_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write address per cycle with registered read data.
// ----------------------------------------------------------------------------
module stbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/sorted_table_binary_search.sv
// ----------------------------------------------------------------------------
// Sorted table binary search
// Stores a table of signed entries and finds a key by halving the range.
//
//   channel  direction  contents
//   req_ch   in         command, entry_index, value
//   rsp_ch   out        found, position (searches only)
//   csr_ch   in         element_count
//
// A search repeats a probe, which reads the table, and a compare, until the
// key is found or the range is empty, and then enters its result state.
// Reset clears the count and the control state; the table has no reset.
// New requests are taken while a response waits; a finished search holds
// in its result state until the response register is free.
// ----------------------------------------------------------------------------
`include "sorted_table_binary_search_macros.svh"

module sorted_table_binary_search #(
   parameter int TABLE_DEPTH = 1024
) (
   input logic      clock,
   input logic      reset,
   stbs_req_if.sink   req_ch,
   stbs_rsp_if.source rsp_ch,
   stbs_csr_if.sink   csr_ch
);

   import stbs_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = ($clog2(TABLE_DEPTH + 1) > COUNT_W) ? $clog2(TABLE_DEPTH + 1) : COUNT_W;

   state_type        state_ff, state_in;
   count_type        count_ff;
   logic [CW-1:0]    lo_ff, lo_in;
   logic [CW-1:0]    end_ff, end_in;
   logic [CW-1:0]    mid_ff, mid;
   logic [CW:0]      mid_sum;
   value_type        key_ff;
   logic             res_found_ff, res_found_in;
   index_type        res_pos_ff, res_pos_in;
   logic             rsp_valid_ff;
   logic             rsp_found_ff;
   index_type        rsp_pos_ff;
   logic [CW-1:0]    count_ext;
   logic [CW-1:0]    count_sat;
   logic [CW-1:0]    idx_ext;
   logic             req_take;
   logic             do_write;
   logic             rsp_free;
   logic [AW-1:0]    ram_addr;
   logic [VALUE_W-1:0] ram_rd;
   value_type        entry;
   logic             key_eq;
   logic             key_gt;

   assign req_ch.ready = (state_ff == ST_IDLE) && !reset;
   assign csr_ch.ready = !reset;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   assign count_ext = CW'(count_ff);
   assign count_sat = (count_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : count_ext;
   assign idx_ext   = CW'(req_ch.entry_index);
   assign do_write  = req_take && (req_ch.command == CMD_WRITE) &&
                      (idx_ext < CW'(TABLE_DEPTH));

   assign mid_sum  = {1'b0, lo_ff} + {1'b0, end_ff} - {{CW{1'b0}}, 1'b1};
   assign mid      = mid_sum[CW:1];
   assign ram_addr = (state_ff == ST_PROBE) ? mid[AW-1:0] : idx_ext[AW-1:0];

   stbs_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (do_write),
      .addr    (ram_addr),
      .wr_data (req_ch.value),
      .rd_data (ram_rd)
   );

   assign entry  = value_type'(ram_rd);
   assign key_eq = (key_ff == entry);
   assign key_gt = (key_ff > entry);

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      end_in       = end_ff;
      res_found_in = res_found_ff;
      res_pos_in   = res_pos_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_ch.command == CMD_SEARCH)) begin
               lo_in        = '0;
               end_in       = count_sat;
               res_found_in = 1'b0;
               res_pos_in   = '0;
               state_in     = (count_sat == '0) ? ST_RESULT : ST_PROBE;
            end
         end
         ST_PROBE: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (key_eq) begin
               res_found_in = 1'b1;
               res_pos_in   = mid_ff[INDEX_W-1:0];
               state_in     = ST_RESULT;
            end else begin
               if (key_gt) begin
                  lo_in = mid_ff + CW'(1);
               end else begin
                  end_in = mid_ff;
               end
               state_in = (lo_in < end_in) ? ST_PROBE : ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_ch.valid && csr_ch.ready) begin
            count_ff <= csr_ch.element_count;
         end
         if ((state_ff == ST_RESULT) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      end_ff       <= end_in;
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
      if (state_ff == ST_PROBE) begin
         mid_ff <= mid;
      end
      if (req_take) begin
         key_ff <= req_ch.value;
      end
      if ((state_ff == ST_RESULT) && rsp_free) begin
         rsp_found_ff <= res_found_ff;
         rsp_pos_ff   <= res_pos_ff;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.found    = rsp_found_ff;
   assign rsp_ch.position = rsp_pos_ff;

   `STBS_ASSERT_IMPLIES(a_probe_range_open, state_ff == ST_PROBE, lo_ff < end_ff)
   `STBS_ASSERT_IMPLIES(a_probe_in_table, state_ff == ST_PROBE, end_ff <= count_sat)
   `STBS_ASSERT_NEXT(a_range_shrinks, (state_ff == ST_CMP) && !key_eq,
                     (end_ff - lo_ff) < ($past(end_ff) - $past(lo_ff)))
   `STBS_ASSERT_NEXT(a_result_waits, (state_ff == ST_RESULT) && rsp_valid_ff && !rsp_ch.ready,
                     state_ff == ST_RESULT)
   `STBS_ASSERT_NEXT(a_result_loads, (state_ff == ST_RESULT) && rsp_free,
                     rsp_valid_ff && (state_ff == ST_IDLE))

endmodule
